[rtl/aall_pkg.sv]
// Shared types and constants for the active alarm linked list unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
package aall_pkg;

    // Default size of the slot table
    localparam int SLOTS_DEF = 16;

    // Link value that means "no neighbour" / "no slot"
    localparam logic [7:0] NONE_SLOT = 8'hFF;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_BADSLOT  = 2'd3;

    // Alarm key as stored in the key memory
    typedef struct packed {
        logic [1:0] key_group;
        logic [4:0] key_bit;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    // Request payload
    typedef struct packed {
        logic [1:0] command;
        logic [1:0] key_group;
        logic [4:0] key_bit;
        logic       is_alarm;
        logic [7:0] query_slot;
    } req_item_t;

    // Response payload
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot;
        logic [7:0] prev_slot;
        logic [7:0] next_slot;
        logic [7:0] newest_slot;
        logic [7:0] entry_count;
        logic [7:0] alarm_count;
    } rsp_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       idle;
        logic       add_step;
        logic       rem_step;
        logic       take_free;
        logic       take_match;
        logic       sel_query;
        logic       add_link;
        logic       add_head;
        logic       rem_fix;
        logic       link_lat;
        logic       set_st;
        logic [1:0] st_val;
        logic       load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       in_fire;
        logic [1:0] req_cmd;
        logic       free_hit;
        logic       add_last;
        logic       match_hit;
        logic       rem_last;
        logic       query_ok;
        logic       out_free;
    } dp_stat_t;

endpackage

[rtl/aall_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on aall_pkg for the payload types.
interface aall_req_if;
    import aall_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aall_rsp_if;
    import aall_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/aall_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aall_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/aall_ctrl.sv]
// Sequencing state machine for add, remove and read operations.
// Depends on aall_pkg for the command and status structs.
module aall_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  aall_pkg::dp_stat_t  stat,
    output aall_pkg::ctrl_cmd_t cmd
);
    import aall_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        ADD_SCAN,
        ADD_LINK,
        ADD_HEAD,
        REM_SCAN,
        REM_RD,
        REM_FIX,
        RD_WAIT,
        DONE
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.in_fire)
                begin
                    state_next = DISPATCH;
                end
            end
            DISPATCH:
            begin
                case (stat.req_cmd)
                    CMD_ADD:    state_next = ADD_SCAN;
                    CMD_REMOVE: state_next = REM_SCAN;
                    CMD_READ:
                    begin
                        if (stat.query_ok)
                        begin
                            cmd.sel_query = 1'b1;
                            state_next    = RD_WAIT;
                        end
                        else
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st_val = ST_BADSLOT;
                            state_next = DONE;
                        end
                    end
                    default:    state_next = DONE;
                endcase
            end
            // one used bit per cycle, lowest first
            ADD_SCAN:
            begin
                cmd.add_step = 1'b1;
                if (stat.free_hit)
                begin
                    cmd.take_free = 1'b1;
                    state_next    = ADD_LINK;
                end
                else if (stat.add_last)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_FULL;
                    state_next = DONE;
                end
            end
            ADD_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next   = ADD_HEAD;
            end
            ADD_HEAD:
            begin
                cmd.add_head = 1'b1;
                state_next   = DONE;
            end
            // pipelined key compare, one slot per cycle
            REM_SCAN:
            begin
                cmd.rem_step = 1'b1;
                if (stat.match_hit)
                begin
                    cmd.take_match = 1'b1;
                    state_next     = REM_RD;
                end
                else if (stat.rem_last)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_NOTFOUND;
                    state_next = DONE;
                end
            end
            REM_RD:
            begin
                state_next = REM_FIX;
            end
            REM_FIX:
            begin
                cmd.rem_fix = 1'b1;
                state_next  = DONE;
            end
            RD_WAIT:
            begin
                cmd.link_lat = 1'b1;
                state_next   = DONE;
            end
            DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

[rtl/aall_dpath.sv]
// Datapath: slot memories, used bits, head and counters, scan logic, output register.
// Depends on aall_pkg, aall_if and aall_ram.
module aall_dpath #(
    parameter int SLOTS = aall_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    aall_req_if.sink            req,
    aall_rsp_if.source          rsp,
    input  aall_pkg::ctrl_cmd_t cmd,
    output aall_pkg::dp_stat_t  stat
);
    import aall_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic             in_fire;
    req_item_t        req_reg;
    logic [SLOTS-1:0] used_reg;
    logic [7:0]       head_reg;
    logic [7:0]       entries_reg;
    logic [7:0]       alarms_reg;
    logic [SW-1:0]    scan_idx_reg;
    logic [SW-1:0]    cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [SW-1:0]    tgt_reg;
    logic             found_reg;
    logic [1:0]       st_reg;
    logic [7:0]       prev_reg;
    logic [7:0]       next_reg;
    logic             out_vld_reg;
    rsp_item_t        out_reg;

    key_t             key_rd;
    logic [7:0]       older_rd;
    logic [7:0]       newer_rd;
    logic [SW-1:0]    link_raddr;
    logic             older_we;
    logic [SW-1:0]    older_waddr;
    logic [7:0]       older_wdata;
    logic             newer_we;
    logic [SW-1:0]    newer_waddr;
    logic [7:0]       newer_wdata;
    logic             o_ok;
    logic             n_ok;
    logic             q_used;
    key_t             req_key;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = cmd.idle;
    assign req_key   = '{key_group: req_reg.key_group, key_bit: req_reg.key_bit};

    // neighbours of the slot being removed
    assign o_ok   = 9'(older_rd) < 9'(SLOTS);
    assign n_ok   = 9'(newer_rd) < 9'(SLOTS);
    assign q_used = used_reg[req_reg.query_slot[SW-1:0]];

    // status to controller
    assign stat.in_fire   = in_fire;
    assign stat.req_cmd   = req_reg.command;
    assign stat.free_hit  = !used_reg[scan_idx_reg];
    assign stat.add_last  = scan_idx_reg == SW'(SLOTS - 1);
    assign stat.match_hit = cmp_vld_reg && used_reg[cmp_idx_reg] && (key_rd == req_key);
    assign stat.rem_last  = cmp_vld_reg && (cmp_idx_reg == SW'(SLOTS - 1));
    assign stat.query_ok  = 9'(req_reg.query_slot) < 9'(SLOTS);
    assign stat.out_free  = !out_vld_reg || rsp.ready;

    // link memory ports
    assign link_raddr = cmd.sel_query ? req_reg.query_slot[SW-1:0] : tgt_reg;

    always_comb
    begin
        older_we    = cmd.add_link || (cmd.rem_fix && n_ok);
        older_waddr = cmd.add_link ? tgt_reg : newer_rd[SW-1:0];
        if (cmd.add_link)
        begin
            older_wdata = (entries_reg == 8'd0) ? NONE_SLOT : head_reg;
        end
        else
        begin
            older_wdata = older_rd;
        end

        newer_we = cmd.add_link || (cmd.add_head && entries_reg != 8'd0)
                   || (cmd.rem_fix && o_ok);
        if (cmd.add_link)
        begin
            newer_waddr = tgt_reg;
            newer_wdata = NONE_SLOT;
        end
        else if (cmd.add_head)
        begin
            newer_waddr = head_reg[SW-1:0];
            newer_wdata = 8'(tgt_reg);
        end
        else
        begin
            newer_waddr = older_rd[SW-1:0];
            newer_wdata = newer_rd;
        end
    end

    aall_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (cmd.add_link),
        .waddr (tgt_reg),
        .wdata (req_key),
        .raddr (scan_idx_reg),
        .rdata (key_rd)
    );

    aall_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .raddr (link_raddr),
        .rdata (older_rd)
    );

    aall_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .raddr (link_raddr),
        .rdata (newer_rd)
    );

    // request capture and per-item result fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            tgt_reg      <= '0;
            found_reg    <= 1'b0;
            st_reg       <= ST_OK;
            prev_reg     <= NONE_SLOT;
            next_reg     <= NONE_SLOT;
        end
        else
        begin
            if (in_fire)
            begin
                scan_idx_reg <= '0;
                cmp_vld_reg  <= 1'b0;
                found_reg    <= 1'b0;
                st_reg       <= ST_OK;
                prev_reg     <= NONE_SLOT;
                next_reg     <= NONE_SLOT;
            end
            if (cmd.add_step || cmd.rem_step)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end
            if (cmd.rem_step)
            begin
                cmp_idx_reg <= scan_idx_reg;
                cmp_vld_reg <= 1'b1;
            end
            if (cmd.take_free)
            begin
                tgt_reg   <= scan_idx_reg;
                found_reg <= 1'b1;
            end
            if (cmd.take_match)
            begin
                tgt_reg   <= cmp_idx_reg;
                found_reg <= 1'b1;
            end
            if (cmd.set_st)
            begin
                st_reg <= cmd.st_val;
            end
            // unused slots always read as unlinked
            if (cmd.link_lat)
            begin
                prev_reg <= q_used ? older_rd : NONE_SLOT;
                next_reg <= q_used ? newer_rd : NONE_SLOT;
            end
        end
    end

    // used bits, head and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            head_reg    <= 8'd0;
            entries_reg <= 8'd0;
            alarms_reg  <= 8'd0;
        end
        else if (cmd.add_head)
        begin
            used_reg[tgt_reg] <= 1'b1;
            head_reg          <= 8'(tgt_reg);
            entries_reg       <= entries_reg + 8'd1;
            if (req_reg.is_alarm && alarms_reg != 8'hFF)
            begin
                alarms_reg <= alarms_reg + 8'd1;
            end
        end
        else if (cmd.rem_fix)
        begin
            used_reg[tgt_reg] <= 1'b0;
            if (older_rd == NONE_SLOT && newer_rd == NONE_SLOT)
            begin
                head_reg <= 8'd0;
            end
            else if (newer_rd == NONE_SLOT)
            begin
                head_reg <= older_rd;
            end
            if (entries_reg != 8'd0)
            begin
                entries_reg <= entries_reg - 8'd1;
                if (req_reg.is_alarm && alarms_reg != 8'd0)
                begin
                    alarms_reg <= alarms_reg - 8'd1;
                end
            end
        end
    end

    // output register, holds until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.status      <= st_reg;
            out_reg.slot        <= found_reg ? 8'(tgt_reg) : NONE_SLOT;
            out_reg.prev_slot   <= prev_reg;
            out_reg.next_slot   <= next_reg;
            out_reg.newest_slot <= head_reg;
            out_reg.entry_count <= entries_reg;
            out_reg.alarm_count <= alarms_reg;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

endmodule

[rtl/active_alarm_linked_list_unit.sv]
// Active alarm list: a slot table of SLOTS entries linked newest-first.
// Depends on aall_pkg, aall_if, aall_ram, aall_ctrl and aall_dpath.
//
// Usage:
//   req carries one command per transfer: add (key_group, key_bit, is_alarm),
//   remove (key_group, key_bit, is_alarm) or read the links of query_slot.
//   rsp returns exactly one result per request: status, the slot touched,
//   the queried links, and head and counts after the operation.
// Flow:
//   One request at a time; req.ready is high only while the sequencer idles.
//   Add scans the used bits one slot a cycle up to the lowest free index, or
//   over every slot when full. Remove compares stored keys one slot a cycle
//   through the registered key memory, up to the match or over every slot.
//   req.ready rises with rsp.valid; the longest operation is a remove that
//   matches the last slot.
// Reset and stall:
//   Reset empties the list at once (used bits cleared, head and counts zero);
//   the key and link memories need no clearing pass.
//   A result waits in the output register while rsp.ready is low; the next
//   request is still taken and its result is held back until that transfer.
module active_alarm_linked_list_unit #(
    parameter int SLOTS = aall_pkg::SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    aall_req_if.sink   req,
    aall_rsp_if.source rsp
);
    import aall_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    aall_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    aall_dpath #(.SLOTS(SLOTS)) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    // a request is never taken back to back: the sequencer leaves idle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an operation is in progress");

    // the list never holds more entries than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.entry_count <= 8'(SLOTS)))
        else $error("entry count exceeds table size");

    // a non-empty list has its head inside the table
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.entry_count != 8'd0) |->
        (9'(rsp.data.newest_slot) < 9'(SLOTS)))
        else $error("head slot outside table while list is not empty");

    // an add reports the slot it touched exactly when it succeeds
    a_slot_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && stat.req_cmd == CMD_ADD) |=>
        ((rsp.data.status == ST_OK) == (rsp.data.slot != NONE_SLOT)))
        else $error("add result status and slot disagree");

endmodule
